// ===== src/integer_divider_64_top_assert.svh =====
// Assertion macros shared by the divider's checker.
`ifndef INTEGER_DIVIDER_64_TOP_ASSERT_SVH
`define INTEGER_DIVIDER_64_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDIV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IDIV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/idiv64_pkg.sv =====
package idiv64_pkg;

  localparam int DATA_W = 64;
  localparam int CMD_W  = 2;
  localparam int CNT_W  = $clog2(DATA_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_DIVMOD = 2'd0,
    CMD_QUOT   = 2'd1,
    CMD_REM    = 2'd2,
    CMD_SDIV   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIX  = 3'b100
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              remainder_written;
  } out_t;

  // Control from the sequencer to the shift-subtract unit.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_t;

endpackage

// ===== src/integer_divider_64_top.sv =====
// 64-bit integer divider. An item is taken when start is high while busy is
// low; busy then stays high until the result is ready. The quotient is built
// one bit per cycle by a single 64-bit shift-subtract unit, so an item goes
// through 64 iterations; the quotient sign is then applied and the fields
// for the command are selected as the result is written into the output
// register. The result appears on result for one cycle with done high and
// must be captured then; busy falls in that same cycle, so the next item may
// be started while done is shown. Commands: unsigned quotient and remainder,
// unsigned quotient, unsigned remainder, and signed quotient.
module integer_divider_64_top
  import idiv64_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  operands,
  output logic done,
  output out_t result
);

  ctrl_t ctl;

  idiv64_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  idiv64_datapath u_datapath (
    .clk      (clk),
    .operands (operands),
    .ctl      (ctl),
    .result   (result)
  );

endmodule

// ===== src/idiv64_ctrl.sv =====
module idiv64_ctrl
  import idiv64_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  done,
  output ctrl_t ctl
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (count == CNT_W'(DATA_W - 1)) state_next = ST_FIX;
      end
      ST_FIX: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FIX);
      if (state == ST_RUN) begin
        count <= count + 1'b1;
      end else begin
        count <= '0;
      end
    end
  end

  assign busy       = (state != ST_IDLE);
  assign ctl.load   = (state == ST_IDLE) && start;
  assign ctl.step   = (state == ST_RUN);
  assign ctl.finish = (state == ST_FIX);

endmodule

// ===== src/idiv64_datapath.sv =====
module idiv64_datapath
  import idiv64_pkg::*;
(
  input  logic  clk,
  input  in_t   operands,
  input  ctrl_t ctl,
  output out_t  result
);

  // The dividend magnitude is loaded into nq and is shifted out at the top while
  // the quotient bits are shifted in at the bottom behind it.
  logic [DATA_W-1:0] nq;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  cmd_t              cmd;
  logic              dvs_zero;
  logic              negate;

  logic              signed_op;
  logic [DATA_W-1:0] mag_n;
  logic [DATA_W-1:0] mag_d;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W+1:0] diff;
  logic              borrow;
  logic [DATA_W-1:0] quot_signed;
  out_t              result_next;

  assign signed_op = (operands.command == CMD_SDIV);
  assign mag_n = (signed_op && operands.dividend[DATA_W-1]) ?
                 (~operands.dividend + 1'b1) : operands.dividend;
  assign mag_d = (signed_op && operands.divisor[DATA_W-1]) ?
                 (~operands.divisor + 1'b1) : operands.divisor;

  assign rem_shift = {rem, nq[DATA_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dvs};
  assign borrow    = diff[DATA_W+1];

  assign quot_signed = negate ? (~nq + 1'b1) : nq;

  always_comb begin
    result_next = '0;
    case (cmd)
      CMD_DIVMOD: begin
        if (!dvs_zero) begin
          result_next.quotient          = nq;
          result_next.remainder         = rem;
          result_next.remainder_written = 1'b1;
        end
      end
      CMD_QUOT: begin
        result_next.quotient = nq;
      end
      CMD_REM: begin
        result_next.remainder         = dvs_zero ? '1 : rem;
        result_next.remainder_written = 1'b1;
      end
      default: begin
        result_next.quotient = quot_signed;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      nq       <= mag_n;
      rem      <= '0;
      dvs      <= mag_d;
      cmd      <= cmd_t'(operands.command);
      dvs_zero <= (operands.divisor == '0);
      negate   <= signed_op && (operands.dividend[DATA_W-1] ^ operands.divisor[DATA_W-1]);
    end else if (ctl.step) begin
      nq  <= {nq[DATA_W-2:0], ~borrow};
      rem <= borrow ? rem_shift[DATA_W-1:0] : diff[DATA_W-1:0];
    end
    if (ctl.finish) begin
      result <= result_next;
    end
  end

endmodule

// ===== src/idiv64_checker.sv =====
`include "integer_divider_64_top_assert.svh"

module idiv64_checker
  import idiv64_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input out_t result
);

  logic accepted;
  logic rem_clear;

  assign accepted  = start && !busy;
  assign rem_clear = result.remainder_written || (result.remainder == '0);

  `IDIV_ASSERT_NEXT(a_busy_after_start, clk, rst, accepted, busy, "busy did not rise on accept")
  `IDIV_ASSERT_NOW(a_latency, clk, rst, accepted, ##66 done, "no result 66 cycles after accept")
  `IDIV_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done held for more than one cycle")
  `IDIV_ASSERT_NOW(a_idle_on_done, clk, rst, done, !busy, "busy high while a result was shown")
  `IDIV_ASSERT_NOW(a_rem_clear, clk, rst, done, rem_clear, "remainder not zero when not written")

endmodule

bind integer_divider_64_top idiv64_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== dv/integer_divider_64_top_tb.sv =====
`timescale 1ns / 100ps

module integer_divider_64_top_tb;
  import idiv64_pkg::*;

  typedef struct {
    in_t op;
    bit  drain;
    bit  calm;
  } div_job_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t  operands = '0;
  logic done;
  out_t result;

  div_job_t pending_divs[$];
  out_t     expected_results[$];
  int       items_accepted = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       gap_left = 0;

  integer_divider_64_top u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_t divide_model(in_t req);
    out_t        res;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] mag_n;
    logic [63:0] mag_d;
    logic        neg_n;
    logic        neg_d;
    res = '0;
    n = req.dividend;
    d = req.divisor;
    case (cmd_t'(req.command))
      CMD_DIVMOD: begin
        if (d != 64'd0) begin
          res.quotient = n / d;
          res.remainder = n % d;
          res.remainder_written = 1'b1;
        end
      end
      CMD_QUOT: begin
        res.quotient = (d == 64'd0) ? '1 : n / d;
      end
      CMD_REM: begin
        res.remainder = (d == 64'd0) ? '1 : n % d;
        res.remainder_written = 1'b1;
      end
      default: begin
        // Magnitudes are taken as unsigned, so the most negative value stays 2^63.
        neg_n = n[63];
        neg_d = d[63];
        mag_n = neg_n ? 64'd0 - n : n;
        mag_d = neg_d ? 64'd0 - d : d;
        res.quotient = (mag_d == 64'd0) ? '1 : mag_n / mag_d;
        if (neg_n != neg_d) res.quotient = 64'd0 - res.quotient;
      end
    endcase
    return res;
  endfunction

  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = v >> $urandom_range(32, 63);
      2: v = '1;
      3: v = {1'b1, 63'd0};
      4: v = {1'b0, {63{1'b1}}};
      5: v = v >> $urandom_range(1, 31);
      6: v = 64'd0 - (v >> $urandom_range(1, 62));
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_division(cmd_t cmd, logic [63:0] n, logic [63:0] d,
                                bit drain, bit calm);
    div_job_t job;
    job.op.command = cmd;
    job.op.dividend = n;
    job.op.divisor = d;
    job.drain = drain;
    job.calm = calm;
    pending_divs.push_back(job);
  endtask

  // Driver: presents queued items and predicts each one as it is taken.
  always @(posedge clk) begin
    bit       took;
    div_job_t job;
    if (rst) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        expected_results.push_back(divide_model(operands));
        items_accepted <= items_accepted + 1;
      end
      if (start && !took) begin
        // Hold the item until the block takes it.
      end else if (gap_left > 0) begin
        start <= 1'b0;
        if (!busy) gap_left = gap_left - 1;
      end else if (pending_divs.size() == 0 ||
                   (pending_divs[0].drain &&
                    (took || results_seen != items_accepted))) begin
        start <= 1'b0;
      end else begin
        job = pending_divs.pop_front();
        operands <= job.op;
        start <= 1'b1;
        if (!job.calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
      end
    end
  end

  // Monitor: the counters are read before this edge's updates, so the check
  // does not depend on the order of the two blocks.
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (results_seen >= items_accepted) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result: quotient %h remainder %h written %b",
                   result.quotient, result.remainder, result.remainder_written);
      end else begin
        want = expected_results.pop_front();
        results_seen <= results_seen + 1;
        if (result.quotient !== want.quotient ||
            result.remainder !== want.remainder ||
            result.remainder_written !== want.remainder_written) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display({"mismatch on result %0d (expected/actual): quotient %h/%h ",
                      "remainder %h/%h written %b/%b"},
                     results_seen, want.quotient, result.quotient,
                     want.remainder, result.remainder,
                     want.remainder_written, result.remainder_written);
        end
      end
    end
  end

  initial begin
    logic [63:0] most_neg;
    logic [63:0] most_pos;
    most_neg = {1'b1, 63'd0};
    most_pos = {1'b0, {63{1'b1}}};

    queue_division(CMD_DIVMOD, 64'd100, 64'd7, 1'b0, 1'b0);
    queue_division(CMD_DIVMOD, 64'd123, 64'd0, 1'b0, 1'b0);
    queue_division(CMD_DIVMOD, '1, 64'd1, 1'b0, 1'b0);
    queue_division(CMD_DIVMOD, 64'd0, '1, 1'b0, 1'b0);
    queue_division(CMD_DIVMOD, '1, '1, 1'b0, 1'b0);
    queue_division(CMD_QUOT, 64'd55, 64'd0, 1'b0, 1'b0);
    queue_division(CMD_QUOT, '1, 64'd3, 1'b0, 1'b0);
    queue_division(CMD_REM, 64'd9, 64'd0, 1'b0, 1'b0);
    queue_division(CMD_REM, '1, most_neg + 64'd1, 1'b0, 1'b0);
    queue_division(CMD_SDIV, 64'd0 - 64'd7, 64'd2, 1'b0, 1'b0);
    queue_division(CMD_SDIV, 64'd7, 64'd0 - 64'd2, 1'b0, 1'b0);
    queue_division(CMD_SDIV, 64'd0 - 64'd7, 64'd0 - 64'd2, 1'b0, 1'b0);
    // Most negative over minus one wraps back to the most negative value.
    queue_division(CMD_SDIV, most_neg, '1, 1'b0, 1'b0);
    queue_division(CMD_SDIV, most_neg, 64'd1, 1'b0, 1'b0);
    queue_division(CMD_SDIV, 64'd42, 64'd0, 1'b0, 1'b0);
    queue_division(CMD_SDIV, 64'd0 - 64'd42, 64'd0, 1'b0, 1'b0);
    queue_division(CMD_SDIV, most_pos, most_neg, 1'b0, 1'b0);
    queue_division(CMD_SDIV, most_neg, most_neg, 1'b0, 1'b0);
    queue_division(CMD_SDIV, 64'd0, '1, 1'b0, 1'b0);

    for (int k = 0; k < 1700; k++)
      queue_division(cmd_t'($urandom_range(0, 3)), random_operand(), random_operand(),
                     (k % 400) == 0, k >= 1500);
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_divs.size() != 0 || start) @(posedge clk);
    while (results_seen != items_accepted) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (expected_results.size() != 0)
        $display("%0d results never arrived", expected_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the divider");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== integer_divider_64_top.f =====
+incdir+src
src/idiv64_pkg.sv
src/idiv64_ctrl.sv
src/idiv64_datapath.sv
src/integer_divider_64_top.sv
src/idiv64_checker.sv
dv/integer_divider_64_top_tb.sv
